### rtl/rotation_matrix_to_quaternion_macros.svh
// assertion macros for the rotation matrix to quaternion block
// used by the port checker; no other dependencies
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// plain clocked assertion
`define RMQ_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion, off while reset is low
`define RMQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### rtl/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

  localparam int IN_W  = 19;  // matrix element width
  localparam int NUM_W = 20;  // sum or difference of two elements
  localparam int Q_W   = 19;  // quaternion component width
  localparam int QUO_W = 18;  // quotient bits below the saturation point

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // side data that travels with an item next to the root
  typedef struct packed {
    branch_t                 branch;
    logic                    degen;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } meta_t;

endpackage

### rtl/rmq_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
// depends on rmq_pkg (meta_t)
module rmq_sqrt_pipe #(
  parameter int A_W = 38,
  parameter int R_W = 19
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [A_W-1:0] in_a,
  input  rmq_pkg::meta_t in_meta,
  output logic           out_valid,
  output logic [R_W-1:0] out_root,
  output rmq_pkg::meta_t out_meta
);

  localparam int PAD_W = 2 * R_W;
  localparam int RM_W  = R_W + 2;

  logic                 valid_r [R_W];
  logic [PAD_W-1:0]     a_r     [R_W];
  logic [R_W-1:0]       root_r  [R_W];
  logic [RM_W-1:0]      rem_r   [R_W];
  rmq_pkg::meta_t       meta_r  [R_W];

  genvar k;
  generate
    for (k = 0; k < R_W; k++) begin : g_stage
      localparam int P = R_W - 1 - k;  // bit pair handled here
      logic             v_in;
      logic [PAD_W-1:0] a_in;
      logic [R_W-1:0]   root_in;
      logic [RM_W-1:0]  rem_in;
      rmq_pkg::meta_t   m_in;
      logic [RM_W+1:0]  rem_sh;
      logic [RM_W+1:0]  trial;
      logic             ge;
      logic [RM_W+1:0]  rem_diff;

      if (k == 0) begin : g_first
        assign v_in    = in_valid;
        assign a_in    = PAD_W'(in_a);
        assign root_in = '0;
        assign rem_in  = '0;
        assign m_in    = in_meta;
      end else begin : g_next
        assign v_in    = valid_r[k-1];
        assign a_in    = a_r[k-1];
        assign root_in = root_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign m_in    = meta_r[k-1];
      end

      assign rem_sh   = {rem_in, a_in[2*P+1 -: 2]};
      assign trial    = (RM_W+2)'({root_in, 2'b01});
      assign ge       = rem_sh >= trial;
      assign rem_diff = rem_sh - trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (en) begin
          valid_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          a_r[k]    <= a_in;
          meta_r[k] <= m_in;
          root_r[k] <= {root_in[R_W-2:0], ge};
          rem_r[k]  <= ge ? rem_diff[RM_W-1:0] : rem_sh[RM_W-1:0];
        end
      end
    end
  endgenerate

  assign out_valid = valid_r[R_W-1];
  assign out_root  = root_r[R_W-1];
  assign out_meta  = meta_r[R_W-1];

endmodule

### rtl/rmq_div_pipe.sv
// pipelined scale of a signed value by 2^frac / divisor, saturated
// depends on rmq_pkg (widths, saturation limits)
module rmq_div_pipe #(
  parameter int FRAC_BITS = 16,
  parameter int D_W       = 20
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rmq_pkg::NUM_W-1:0]     in_n,
  input  logic [D_W-1:0]                       in_d,
  output logic signed [rmq_pkg::Q_W-1:0]       out_q
);

  localparam int QW  = rmq_pkg::QUO_W;
  localparam int N_W = rmq_pkg::NUM_W + FRAC_BITS;
  localparam int C_W = (N_W > D_W + QW) ? N_W : D_W + QW;

  // front stage: magnitude, sign and overflow test
  logic [rmq_pkg::NUM_W-1:0] mag;
  logic [C_W-1:0]            numer;
  logic [C_W-1:0]            dlim;

  assign mag   = in_n[rmq_pkg::NUM_W-1] ? rmq_pkg::NUM_W'(-in_n) : rmq_pkg::NUM_W'(in_n);
  assign numer = C_W'(mag) << FRAC_BITS;
  assign dlim  = C_W'(in_d) << QW;

  logic [C_W-1:0] rem_f_r;
  logic [D_W-1:0] d_f_r;
  logic           neg_f_r;
  logic           ovf_f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_f_r <= numer;
      d_f_r   <= in_d;
      neg_f_r <= in_n[rmq_pkg::NUM_W-1];
      ovf_f_r <= numer >= dlim;
    end
  end

  logic [C_W-1:0] rem_r [QW];
  logic [D_W-1:0] d_r   [QW];
  logic [QW-1:0]  q_r   [QW];
  logic           neg_r [QW];
  logic           ovf_r [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;  // quotient bit handled here
      logic [C_W-1:0] rem_in;
      logic [D_W-1:0] d_in;
      logic [QW-1:0]  q_in;
      logic           neg_in;
      logic           ovf_in;
      logic [C_W-1:0] dsh;
      logic           ge;

      if (k == 0) begin : g_first
        assign rem_in = rem_f_r;
        assign d_in   = d_f_r;
        assign q_in   = '0;
        assign neg_in = neg_f_r;
        assign ovf_in = ovf_f_r;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign d_in   = d_r[k-1];
        assign q_in   = q_r[k-1];
        assign neg_in = neg_r[k-1];
        assign ovf_in = ovf_r[k-1];
      end

      assign dsh = C_W'(d_in) << B;
      assign ge  = rem_in >= dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_in - dsh : rem_in;
          d_r[k]   <= d_in;
          q_r[k]   <= {q_in[QW-2:0], ge};
          neg_r[k] <= neg_in;
          ovf_r[k] <= ovf_in;
        end
      end
    end
  endgenerate

  logic signed [rmq_pkg::Q_W-1:0] q_ext;
  assign q_ext = $signed(rmq_pkg::Q_W'(q_r[QW-1]));

  always_comb begin
    if (ovf_r[QW-1]) begin
      out_q = neg_r[QW-1] ? rmq_pkg::Q_MIN : rmq_pkg::Q_MAX;
    end else begin
      out_q = neg_r[QW-1] ? -q_ext : q_ext;
    end
  end

endmodule

### rtl/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to quaternion, fixed point, fully pipelined
// depends on rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe
//
// usage
//   input channel: in_valid / in_stall with ten signed matrix elements
//   (m00..m22 and m33) in fixed point with FRAC_BITS fraction bits
//   result channel: out_valid / out_stall with qx, qy, qz, qw, the branch
//   taken and a degenerate flag (all components zero when set)
//   an item is taken at a clock edge where valid is high and stall is low
//   throughput: one item per cycle, no gaps between items, while in_stall is low
//   path: stage 1, stage 2, the root pipeline (one root bit per stage;
//   R_W = (ARG_W - 1 + FRAC_BITS + 1) / 2 is the root width), the
//   divider front stage and its 18 quotient stages, the output register
//   reset (synchronous, rst_n low) clears every valid bit; items in flight
//   are dropped
//   when the receiver stalls a waiting result, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is lost or repeated
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m00,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m01,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m02,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m10,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m11,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m12,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m20,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m21,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m22,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m33,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rmq_pkg::Q_W-1:0]    out_qx,
  output logic signed [rmq_pkg::Q_W-1:0]    out_qy,
  output logic signed [rmq_pkg::Q_W-1:0]    out_qz,
  output logic signed [rmq_pkg::Q_W-1:0]    out_qw,
  output logic [1:0]                        out_branch_used,
  output logic                              out_degenerate
);

  localparam int IW     = rmq_pkg::IN_W;
  localparam int NW     = rmq_pkg::NUM_W;
  localparam int QW     = rmq_pkg::Q_W;
  localparam int TR_W   = IW + 2;  // three-element trace
  // square-root argument, wide enough for trace + one at any FRAC_BITS
  localparam int ARG_W  = (FRAC_BITS + 2 > IW + 4) ? FRAC_BITS + 2 : IW + 4;
  localparam int A_W    = ARG_W - 1 + FRAC_BITS;
  localparam int R_W    = (A_W + 1) / 2;
  localparam int D_W    = R_W + 1;
  localparam int DIV_D  = rmq_pkg::QUO_W + 1;  // divider depth
  localparam int HC_W   = (R_W > QW) ? R_W : QW;
  localparam logic signed [ARG_W-1:0] ONE_FX = ARG_W'(1) << FRAC_BITS;

  // the whole pipeline moves together; it holds only while a result waits
  logic en;
  logic out_valid_r;
  assign in_stall = out_valid_r && out_stall;
  assign en       = !in_stall;

  // stage 1: trace, largest diagonal element, pairwise sums and differences
  logic signed [TR_W-1:0] trace_c;
  logic                   h1, h2;
  logic signed [IW-1:0]   hv;
  rmq_pkg::branch_t       diag_br_c;
  logic signed [IW-1:0]   mhh_c;

  assign trace_c = TR_W'(in_m00) + TR_W'(in_m11) + TR_W'(in_m22);
  assign h1      = in_m11 > in_m00;  // ties keep the earlier element
  assign hv      = h1 ? in_m11 : in_m00;
  assign h2      = in_m22 > hv;

  always_comb begin
    priority if (h2) begin
      diag_br_c = rmq_pkg::BR_Z;
      mhh_c     = in_m22;
    end else if (h1) begin
      diag_br_c = rmq_pkg::BR_Y;
      mhh_c     = in_m11;
    end else begin
      diag_br_c = rmq_pkg::BR_X;
      mhh_c     = in_m00;
    end
  end

  logic                   s1_valid_r;
  logic signed [TR_W-1:0] s1_trace_r;
  rmq_pkg::branch_t       s1_diag_br_r;
  logic signed [IW-1:0]   s1_mhh_r;
  logic signed [IW-1:0]   s1_m33_r;
  logic signed [NW-1:0]   s1_d21_12_r, s1_d02_20_r, s1_d10_01_r;
  logic signed [NW-1:0]   s1_s01_10_r, s1_s20_02_r, s1_s12_21_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_trace_r   <= trace_c;
      s1_diag_br_r <= diag_br_c;
      s1_mhh_r     <= mhh_c;
      s1_m33_r     <= in_m33;
      s1_d21_12_r  <= NW'(in_m21) - NW'(in_m12);
      s1_d02_20_r  <= NW'(in_m02) - NW'(in_m20);
      s1_d10_01_r  <= NW'(in_m10) - NW'(in_m01);
      s1_s01_10_r  <= NW'(in_m01) + NW'(in_m10);
      s1_s20_02_r  <= NW'(in_m20) + NW'(in_m02);
      s1_s12_21_r  <= NW'(in_m12) + NW'(in_m21);
    end
  end

  // stage 2: branch, square-root argument, numerator routing
  rmq_pkg::branch_t        br_c;
  logic signed [ARG_W-1:0] arg_c;
  logic                    degen_c;
  logic [A_W-1:0]          a_c;
  rmq_pkg::meta_t          meta_c;

  always_comb begin
    if (!s1_trace_r[TR_W-1]) begin
      br_c  = rmq_pkg::BR_TRACE;
      arg_c = ARG_W'(s1_trace_r) + ONE_FX;
    end else begin
      // diagonal branch: m_hh - (other two) + m33 = 2 m_hh - trace + m33
      br_c  = s1_diag_br_r;
      arg_c = ARG_W'(s1_mhh_r) + ARG_W'(s1_mhh_r) - ARG_W'(s1_trace_r) + ARG_W'(s1_m33_r);
    end
  end

  assign degen_c = arg_c[ARG_W-1] || (arg_c == '0);
  assign a_c     = degen_c ? '0 : (A_W'(arg_c[ARG_W-2:0]) << FRAC_BITS);

  // n0..n2 are the three non-root components in x, y, z, w order
  always_comb begin
    meta_c.branch = br_c;
    meta_c.degen  = degen_c;
    unique case (br_c)
      rmq_pkg::BR_TRACE: begin
        meta_c.n0 = s1_d21_12_r;
        meta_c.n1 = s1_d02_20_r;
        meta_c.n2 = s1_d10_01_r;
      end
      rmq_pkg::BR_X: begin
        meta_c.n0 = s1_s01_10_r;
        meta_c.n1 = s1_s20_02_r;
        meta_c.n2 = s1_d21_12_r;
      end
      rmq_pkg::BR_Y: begin
        meta_c.n0 = s1_s01_10_r;
        meta_c.n1 = s1_s12_21_r;
        meta_c.n2 = s1_d02_20_r;
      end
      rmq_pkg::BR_Z: begin
        meta_c.n0 = s1_s20_02_r;
        meta_c.n1 = s1_s12_21_r;
        meta_c.n2 = s1_d10_01_r;
      end
      default: begin
        meta_c.n0 = '0;
        meta_c.n1 = '0;
        meta_c.n2 = '0;
      end
    endcase
  end

  logic           s2_valid_r;
  logic [A_W-1:0] s2_a_r;
  rmq_pkg::meta_t s2_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a_r    <= a_c;
      s2_meta_r <= meta_c;
    end
  end

  // square root, one bit per stage
  logic           sq_valid;
  logic [R_W-1:0] sq_root;
  rmq_pkg::meta_t sq_meta;

  rmq_sqrt_pipe #(
    .A_W (A_W),
    .R_W (R_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_valid_r),
    .in_a      (s2_a_r),
    .in_meta   (s2_meta_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_meta  (sq_meta)
  );

  // selected component is half the root, saturated
  logic [R_W-1:0]          half_w;
  logic signed [QW-1:0]    half_c;
  logic [D_W-1:0]          dvs;

  assign half_w = sq_root >> 1;
  assign half_c = (HC_W'(half_w) > HC_W'(rmq_pkg::Q_MAX)) ? rmq_pkg::Q_MAX
                                                         : $signed(QW'(half_w));
  assign dvs    = {sq_root, 1'b0};

  // three scale units, one per non-root component
  logic signed [QW-1:0] q0, q1, q2;

  rmq_div_pipe #(.FRAC_BITS (FRAC_BITS), .D_W (D_W)) u_div0 (
    .clk (clk), .en (en), .in_n (sq_meta.n0), .in_d (dvs), .out_q (q0)
  );
  rmq_div_pipe #(.FRAC_BITS (FRAC_BITS), .D_W (D_W)) u_div1 (
    .clk (clk), .en (en), .in_n (sq_meta.n1), .in_d (dvs), .out_q (q1)
  );
  rmq_div_pipe #(.FRAC_BITS (FRAC_BITS), .D_W (D_W)) u_div2 (
    .clk (clk), .en (en), .in_n (sq_meta.n2), .in_d (dvs), .out_q (q2)
  );

  // side data delay line matching the scale units
  logic                 dl_valid_r [DIV_D];
  rmq_pkg::branch_t     dl_br_r    [DIV_D];
  logic                 dl_degen_r [DIV_D];
  logic signed [QW-1:0] dl_half_r  [DIV_D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_D; i++) begin
        dl_valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      dl_valid_r[0] <= sq_valid;
      for (int i = 1; i < DIV_D; i++) begin
        dl_valid_r[i] <= dl_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_br_r[0]    <= sq_meta.branch;
      dl_degen_r[0] <= sq_meta.degen;
      dl_half_r[0]  <= half_c;
      for (int i = 1; i < DIV_D; i++) begin
        dl_br_r[i]    <= dl_br_r[i-1];
        dl_degen_r[i] <= dl_degen_r[i-1];
        dl_half_r[i]  <= dl_half_r[i-1];
      end
    end
  end

  // output stage: put the root component in its slot, zero degenerate items
  rmq_pkg::branch_t     f_br;
  logic signed [QW-1:0] f_half;
  logic signed [QW-1:0] qx_c, qy_c, qz_c, qw_c;

  assign f_br   = dl_br_r[DIV_D-1];
  assign f_half = dl_half_r[DIV_D-1];

  always_comb begin
    unique case (f_br)
      rmq_pkg::BR_TRACE: begin
        qx_c = q0;     qy_c = q1;     qz_c = q2;     qw_c = f_half;
      end
      rmq_pkg::BR_X: begin
        qx_c = f_half; qy_c = q0;     qz_c = q1;     qw_c = q2;
      end
      rmq_pkg::BR_Y: begin
        qx_c = q0;     qy_c = f_half; qz_c = q1;     qw_c = q2;
      end
      rmq_pkg::BR_Z: begin
        qx_c = q0;     qy_c = q1;     qz_c = f_half; qw_c = q2;
      end
      default: begin
        qx_c = '0;     qy_c = '0;     qz_c = '0;     qw_c = '0;
      end
    endcase
    if (dl_degen_r[DIV_D-1]) begin
      qx_c = '0;
      qy_c = '0;
      qz_c = '0;
      qw_c = '0;
    end
  end

  logic signed [QW-1:0] qx_r, qy_r, qz_r, qw_r;
  logic [1:0]           br_r;
  logic                 degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dl_valid_r[DIV_D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r    <= qx_c;
      qy_r    <= qy_c;
      qz_r    <= qz_c;
      qw_r    <= qw_c;
      br_r    <= f_br;
      degen_r <= dl_degen_r[DIV_D-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_qx          = qx_r;
  assign out_qy          = qy_r;
  assign out_qz          = qz_r;
  assign out_qw          = qw_r;
  assign out_branch_used = br_r;
  assign out_degenerate  = degen_r;

endmodule

### rtl/rmq_checker.sv
// port checker for the rotation matrix to quaternion block, with its bind
// depends on rmq_pkg and rotation_matrix_to_quaternion_macros.svh
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [rmq_pkg::Q_W-1:0] out_qx,
  input logic signed [rmq_pkg::Q_W-1:0] out_qy,
  input logic signed [rmq_pkg::Q_W-1:0] out_qz,
  input logic signed [rmq_pkg::Q_W-1:0] out_qw,
  input logic [1:0]                     out_branch_used,
  input logic                           out_degenerate
);

  // reset empties the result register
  `RMQ_ASSERT(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // input side holds only behind a waiting, stalled result
  `RMQ_ASSERT_RST(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled without cause")

  // a stalled result stays valid and keeps its qx and qw
  `RMQ_ASSERT_RST(a_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_qw) && $stable(out_qx)), "stalled item changed")

  // degenerate items carry a zero quaternion
  `RMQ_ASSERT_RST(a_degen_zero, clk, rst_n, (out_valid && out_degenerate) |-> (out_qx == '0 && out_qy == '0 && out_qz == '0 && out_qw == '0), "degenerate item not zero")

  // on the trace branch w is half a root and never negative
  `RMQ_ASSERT_RST(a_trace_w, clk, rst_n, (out_valid && !out_degenerate && out_branch_used == rmq_pkg::BR_TRACE) |-> !out_qw[rmq_pkg::Q_W-1], "negative w on trace branch")

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_qx          (out_qx),
  .out_qy          (out_qy),
  .out_qz          (out_qz),
  .out_qw          (out_qw),
  .out_branch_used (out_branch_used),
  .out_degenerate  (out_degenerate)
);
